[hdl/lbps_pkg.sv]
// Shared types, pattern tables and codes for the LED blink pattern sequencer.
// Used by lbps_led and led_blink_pattern_sequencer_core; no other dependencies.
package lbps_pkg;

  localparam int NUM_LEDS = 2;
  localparam int DUR_W    = 10;
  localparam int STEP_W   = 3;
  localparam int PAT_W    = 4;

  localparam logic [DUR_W-1:0] ELAPSED_MAX = '1;

  // Operation codes carried on the input channel.
  typedef enum logic [1:0] {
    OP_TICK      = 2'd0,
    OP_SET_READY = 2'd1,
    OP_SET_ROLE  = 2'd2,
    OP_NOP       = 2'd3
  } op_t;

  // Role codes of the set-role command.
  localparam logic [2:0] ROLE_MASTER = 3'd1;
  localparam logic [2:0] ROLE_SLAVE  = 3'd2;

  // Pattern numbers: 0..7 ready patterns, then the role patterns.
  localparam logic [PAT_W-1:0] PAT_UNKNOWN = 4'd8;
  localparam logic [PAT_W-1:0] PAT_MASTER  = 4'd9;
  localparam logic [PAT_W-1:0] PAT_SLAVE   = 4'd10;
  localparam logic [PAT_W-1:0] PAT_NONE    = 4'd15;

  // Configuration register index.
  localparam logic REG_LED_COUNT = 1'b0;

  // Per-LED control for one accepted item.
  typedef struct packed {
    logic             clear;
    logic             tick;
    logic             sel;
    logic [PAT_W-1:0] pat;
  } led_ctl_t;

  function automatic logic [STEP_W-1:0] step_count(input logic [PAT_W-1:0] pat);
    case (pat)
      4'd2, 4'd4: step_count = 3'd4;
      4'd7:       step_count = 3'd6;
      default:    step_count = 3'd2;
    endcase
  endfunction

  function automatic logic [DUR_W-1:0] step_dur(input logic [PAT_W-1:0] pat,
                                                input logic [STEP_W-1:0] st);
    logic [DUR_W-1:0] d;
    d = '0;
    case (pat)
      4'd0: d = (st == 3'd0) ? 10'd120 : 10'd380;
      4'd1: d = (st == 3'd0) ? 10'd120 : 10'd880;
      4'd2: d = (st == 3'd3) ? 10'd640 : 10'd120;
      4'd3: d = 10'd150;
      4'd4: d = (st == 3'd3) ? 10'd720 : ((st == 3'd1) ? 10'd120 : 10'd80);
      4'd5: d = 10'd220;
      4'd6: d = 10'd500;
      4'd7: d = (st == 3'd5) ? 10'd500 : 10'd80;
      4'd8: d = (st == 3'd0) ? 10'd90 : 10'd910;
      default: d = '0;
    endcase
    return d;
  endfunction

  // Blinking patterns are on at every even step and off at every odd one.
  function automatic logic step_level(input logic [STEP_W-1:0] st);
    return ~st[0];
  endfunction

endpackage

[hdl/lbps_led.sv]
// State and step logic of one status LED: active pattern, step, timer, level.
// Depends on lbps_pkg for the pattern tables and the control struct.
module lbps_led
  import lbps_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  led_ctl_t ctl,
  output logic     level_nxt
);

  logic [PAT_W-1:0]  pat_r,  pat_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [DUR_W-1:0]  ms_r,   ms_nxt;
  logic              lvl_r,  lvl_nxt;

  logic [STEP_W-1:0] cnt;
  logic [STEP_W-1:0] st_cur;
  logic [STEP_W-1:0] st_inc;
  logic [DUR_W-1:0]  ms_inc;

  always_comb begin
    cnt    = step_count(pat_r);
    st_cur = (step_r >= cnt) ? '0 : step_r;
    st_inc = st_cur + 3'd1;
    if (st_inc >= cnt) begin
      st_inc = '0;
    end
    ms_inc = (ms_r == ELAPSED_MAX) ? ELAPSED_MAX : ms_r + 10'd1;

    pat_nxt  = pat_r;
    step_nxt = step_r;
    ms_nxt   = ms_r;
    lvl_nxt  = lvl_r;
    if (ctl.clear) begin
      pat_nxt  = PAT_NONE;
      step_nxt = '0;
      ms_nxt   = '0;
      lvl_nxt  = 1'b0;
    end else if (ctl.sel && ctl.pat != pat_r) begin
      pat_nxt  = ctl.pat;
      step_nxt = '0;
      ms_nxt   = '0;
      if (ctl.pat == PAT_MASTER) begin
        lvl_nxt = 1'b1;
      end else if (ctl.pat == PAT_SLAVE) begin
        lvl_nxt = 1'b0;
      end else begin
        lvl_nxt = step_level('0);
      end
    end else if (ctl.tick && pat_r <= PAT_UNKNOWN) begin
      if (ms_inc >= step_dur(pat_r, st_cur)) begin
        step_nxt = st_inc;
        lvl_nxt  = step_level(st_inc);
        ms_nxt   = '0;
      end else begin
        ms_nxt = ms_inc;
      end
    end
  end

  assign level_nxt = lvl_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r  <= PAT_NONE;
      step_r <= '0;
      ms_r   <= '0;
      lvl_r  <= 1'b0;
    end else begin
      pat_r  <= pat_nxt;
      step_r <= step_nxt;
      ms_r   <= ms_nxt;
      lvl_r  <= lvl_nxt;
    end
  end

endmodule

[hdl/led_blink_pattern_sequencer_core.sv]
// Top level of the LED blink pattern sequencer: stream ports, APB register,
// input and result registers, and two lbps_led instances. Uses lbps_pkg.
//
// Channel  | Direction | Handshake            | Payload
// ---------+-----------+----------------------+---------------------------------------
// in       | slave     | in_tvalid/in_tready  | tuser: operation; tdata: pattern_code
// out      | master    | out_tvalid/out_tready| tuser: command_ignored; tdata: levels
// cfg      | APB slave | psel/penable/pready  | register 0 = led_count (2 bits)
//
// An accepted item waits in the input register; in the cycle it leaves,
// the LED state updates and the result register loads, and the result
// register drives the output directly. A new item can be taken every cycle
// while the output is not stalled.
// The input register empties whenever the result register is free or being
// drained, so out_tready low stalls the input only once both registers hold.
// Reset (rst_n, synchronous) empties both registers, sets led_count to 0
// and puts both LEDs in the no-pattern state with the level low.
// A write to led_count clears the LED state in the same cycle.
module led_blink_pattern_sequencer_core
  import lbps_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Input item stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [2:0] pattern_code, [7:3] zero
  input  logic [1:0]  in_tuser,   // [1:0] operation
  // Result item stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [0] led0_level, [1] led1_level, [7:2] zero
  output logic        out_tuser,  // [0] command_ignored
  // Configuration port.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // Input register.
  logic       in_v_r;
  logic [1:0] op_r;
  logic [2:0] code_r;

  // Result register.
  logic       out_v_r;
  logic [1:0] lvl_r, lvl_nxt;
  logic       ign_r, ign_nxt;

  logic [1:0] led_count_r;
  logic       cfg_wr;
  logic       advance;
  logic       use0, use1;
  led_ctl_t   ctl0, ctl1;
  logic       lvl0_nxt, lvl1_nxt;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[2] == REG_LED_COUNT;
  assign cfg_prdata = (cfg_paddr[2] == REG_LED_COUNT) ? {30'd0, led_count_r} : 32'd0;

  // Counts above the number of LEDs saturate, so LED 1 is in use for 2 and 3.
  assign use0 = led_count_r != 2'd0;
  assign use1 = led_count_r[1];

  assign advance   = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || advance;

  always_comb begin
    ctl0       = '0;
    ctl1       = '0;
    ctl0.clear = cfg_wr;
    ctl1.clear = cfg_wr;
    ctl0.pat   = {1'b0, code_r};
    if (code_r == ROLE_MASTER) begin
      ctl1.pat = PAT_MASTER;
    end else if (code_r == ROLE_SLAVE) begin
      ctl1.pat = PAT_SLAVE;
    end else begin
      ctl1.pat = PAT_UNKNOWN;
    end
    ign_nxt = 1'b0;
    if (advance) begin
      case (op_t'(op_r))
        OP_TICK: begin
          ctl0.tick = use0;
          ctl1.tick = use1;
        end
        OP_SET_READY: begin
          ctl0.sel = use0;
          ign_nxt  = !use0;
        end
        OP_SET_ROLE: begin
          ctl1.sel = use1;
          ign_nxt  = !use1;
        end
        default: begin
        end
      endcase
    end
    lvl_nxt = {lvl1_nxt & use1, lvl0_nxt & use0};
  end

  lbps_led u_led0 (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl0),
    .level_nxt (lvl0_nxt)
  );

  lbps_led u_led1 (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl1),
    .level_nxt (lvl1_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r      <= 1'b0;
      out_v_r     <= 1'b0;
      led_count_r <= '0;
    end else begin
      if (in_tready) begin
        in_v_r <= in_tvalid;
      end
      if (advance) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
      if (cfg_wr) begin
        led_count_r <= cfg_pwdata[1:0];
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      op_r   <= in_tuser;
      code_r <= in_tdata[2:0];
    end
    if (advance) begin
      lvl_r <= lvl_nxt;
      ign_r <= ign_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {6'd0, lvl_r};
  assign out_tuser  = ign_r;

endmodule
